FILE: rtl/core/huffman_table_decoder_assert.svh
// assertion macros for the huffman table decoder
`ifndef HUFFMAN_TABLE_DECODER_ASSERT_SVH
`define HUFFMAN_TABLE_DECODER_ASSERT_SVH
`ifndef SYNTHESIS
`define HUFD_ASSERT_ALWAYS(label, clk, rstn, cond) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (cond)) \
        else $error("hufd check failed");
`define HUFD_ASSERT_IMPLY(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("hufd check failed");
`else
`define HUFD_ASSERT_ALWAYS(label, clk, rstn, cond)
`define HUFD_ASSERT_IMPLY(label, clk, rstn, ante, cons)
`endif
`endif

FILE: rtl/core/hufd_pkg.sv
// shared types and constants of the huffman table decoder
`default_nettype none
package hufd_pkg;
    localparam logic MODE_LOAD = 1'b0;
    localparam logic MODE_DATA = 1'b1;

    localparam logic REG_SYMBOL_TOTAL  = 1'b0;
    localparam logic REG_TABLE_ENTRIES = 1'b1;

    localparam int RESULT_LIMIT = 8;
    localparam int QUEUE_DEPTH  = 4;

    // one table slot as stored in the code ram
    typedef struct packed {
        logic [7:0]  symbol;
        logic [5:0]  length;
        logic [31:0] code;
    } tentry_t;

    // one classified item on its way to the decoder
    typedef struct packed {
        logic        is_load;
        logic [7:0]  index;
        tentry_t     entry;
        logic [7:0]  data_byte;
    } item_t;

    // one decoded result
    typedef struct packed {
        logic [7:0] symbol;
        logic       last;
        logic       done_res;
        logic       error;
    } result_t;
endpackage
`default_nettype wire

FILE: rtl/core/hufd_ram.sv
// generic single-write, single-read ram with registered read data
`default_nettype none
module hufd_ram #(
    parameter int WIDTH = 46,
    parameter int DEPTH = 256
) (
    input  wire logic                     aclk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic                     rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);
    logic [WIDTH-1:0] mem [DEPTH];

    // write port and registered read port
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data <= mem[rd_addr];
        end
    end
endmodule
`default_nettype wire

FILE: rtl/core/hufd_queue.sv
// short register queue between the front and back parts
`default_nettype none
module hufd_queue #(
    parameter int WIDTH = 63,
    parameter int DEPTH = 4
) (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             push_valid,
    output logic                  push_ready,
    input  wire logic [WIDTH-1:0] push_data,
    output logic                  pop_valid,
    input  wire logic             pop_ready,
    output logic      [WIDTH-1:0] pop_data
);
    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_push, do_pop;

    assign push_ready = (count_reg != CNT_W'(DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign pop_data   = mem_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    // pointer and fill count update
    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop) begin
            count_next = count_reg + 1'b1;
        end else if (do_pop && !do_push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // storage, no reset needed
    always_ff @(posedge aclk) begin
        if (do_push) begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end
endmodule
`default_nettype wire

FILE: rtl/core/hufd_front.sv
// input stage: takes transfers, unpacks and classifies them
`default_nettype none
module hufd_front #(
    parameter int TABLE_DEPTH = 256
) (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          s_tvalid,
    output logic               s_tready,
    input  wire logic [63:0]   s_tdata,
    input  wire logic          s_tuser,
    output logic               push_valid,
    input  wire logic          push_ready,
    output hufd_pkg::item_t    push_item
);
    logic             fr_valid_reg, fr_valid_next;
    hufd_pkg::item_t  fr_item_reg, fr_item_next;
    hufd_pkg::item_t  in_item;
    logic             keep;

    // unpack the transfer
    always_comb begin
        in_item.is_load      = (s_tuser == hufd_pkg::MODE_LOAD);
        in_item.index        = s_tdata[7:0];
        in_item.entry.symbol = s_tdata[15:8];
        in_item.entry.length = s_tdata[21:16];
        in_item.entry.code   = s_tdata[53:22];
        in_item.data_byte    = s_tdata[61:54];
    end

    // loads to a slot beyond the table are dropped here
    assign keep = !in_item.is_load || ({1'b0, in_item.index} < 9'(TABLE_DEPTH));

    assign s_tready   = !fr_valid_reg || push_ready;
    assign push_valid = fr_valid_reg;
    assign push_item  = fr_item_reg;

    always_comb begin
        fr_valid_next = fr_valid_reg;
        fr_item_next  = fr_item_reg;
        if (s_tvalid && s_tready) begin
            fr_valid_next = keep;
            fr_item_next  = in_item;
        end else if (push_ready) begin
            fr_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fr_valid_reg <= 1'b0;
        end else begin
            fr_valid_reg <= fr_valid_next;
        end
        fr_item_reg <= fr_item_next;
    end
endmodule
`default_nettype wire

FILE: rtl/core/hufd_back.sv
// decode engine: table writes, bit buffer, table search, result output
`default_nettype none
module hufd_back #(
    parameter int TABLE_DEPTH  = 256,
    parameter int MAX_CODE_LEN = 32
) (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          cfg_valid,
    input  wire logic          cfg_index,
    input  wire logic [31:0]   cfg_data,
    input  wire logic          pop_valid,
    output logic               pop_ready,
    input  wire hufd_pkg::item_t pop_item,
    output logic               m_tvalid,
    input  wire logic          m_tready,
    output hufd_pkg::result_t  m_result
);
    localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int LIM_W = IDX_W + 1;
    localparam int BUF_W = MAX_CODE_LEN + 7;
    localparam int CNT_W = $clog2(BUF_W + 1);
    localparam int EXT_W = (BUF_W > 32) ? BUF_W : 32;
    localparam int ENT_W = $bits(hufd_pkg::tentry_t);
    localparam int NRES_W = $clog2(hufd_pkg::RESULT_LIMIT + 1);

    localparam logic [1:0] ST_IDLE   = 2'd0;
    localparam logic [1:0] ST_SCAN   = 2'd1;
    localparam logic [1:0] ST_DECIDE = 2'd2;
    localparam logic [1:0] ST_FLUSH  = 2'd3;

    logic [1:0]         state_reg, state_next;
    logic [31:0]        total_reg, total_next;
    logic [8:0]         entries_reg, entries_next;
    logic [BUF_W-1:0]   buf_reg, buf_next;
    logic [CNT_W-1:0]   cnt_reg, cnt_next;
    logic [31:0]        emitted_reg, emitted_next;
    logic               err_reg, err_next;
    logic [NRES_W-1:0]  nres_reg, nres_next;
    logic [LIM_W-1:0]   issue_reg, issue_next;
    logic               cmp_v_reg, cmp_v_next;
    logic               found_reg, found_next;
    logic [5:0]         best_len_reg, best_len_next;
    logic [7:0]         best_sym_reg, best_sym_next;
    logic               pend_v_reg, pend_v_next;
    hufd_pkg::result_t  pend_reg, pend_next;
    logic               m_valid_reg, m_valid_next;
    hufd_pkg::result_t  m_res_reg, m_res_next;

    logic               ram_wr_en, ram_rd_en;
    logic [IDX_W-1:0]   ram_rd_addr;
    logic [ENT_W-1:0]   ram_rd_data;
    hufd_pkg::tentry_t  rd_entry;
    logic [LIM_W-1:0]   lim;
    logic               out_free, stream_live;
    logic [CNT_W-1:0]   shamt, cnt_left;
    logic [EXT_W-1:0]   len_mask, ext_front, ext_code;
    logic [BUF_W-1:0]   left_mask;
    logic               len_ok, match, better, term;
    hufd_pkg::result_t  new_res;

    hufd_ram #(
        .WIDTH(ENT_W),
        .DEPTH(TABLE_DEPTH)
    ) u_ram (
        .aclk   (aclk),
        .wr_en  (ram_wr_en),
        .wr_addr(IDX_W'(pop_item.index)),
        .wr_data(pop_item.entry),
        .rd_en  (ram_rd_en),
        .rd_addr(ram_rd_addr),
        .rd_data(ram_rd_data)
    );

    assign pop_ready = (state_reg == ST_IDLE);
    assign ram_wr_en = (state_reg == ST_IDLE) && pop_valid && pop_item.is_load;
    assign lim = (32'(entries_reg) > TABLE_DEPTH) ? LIM_W'(TABLE_DEPTH) : LIM_W'(entries_reg);
    assign ram_rd_en   = (state_reg == ST_SCAN) && (issue_reg < lim);
    assign ram_rd_addr = issue_reg[IDX_W-1:0];
    assign out_free    = !m_valid_reg || m_tready;
    assign stream_live = !err_reg && (emitted_reg < total_reg);
    assign m_tvalid    = m_valid_reg;
    assign m_result    = m_res_reg;

    // compare the slot read last cycle against the front of the buffer
    always_comb begin
        rd_entry  = hufd_pkg::tentry_t'(ram_rd_data);
        len_ok    = (rd_entry.length != 6'd0) && (rd_entry.length <= 6'd32)
                    && (32'(rd_entry.length) <= MAX_CODE_LEN)
                    && (32'(rd_entry.length) <= 32'(cnt_reg));
        shamt     = cnt_reg - CNT_W'(rd_entry.length);
        len_mask  = ~({EXT_W{1'b1}} << rd_entry.length);
        ext_front = (EXT_W'(buf_reg) >> shamt) & len_mask;
        ext_code  = EXT_W'(rd_entry.code) & len_mask;
        match     = len_ok && (ext_front == ext_code);
        better    = match && (!found_reg || (rd_entry.length < best_len_reg));
    end

    // consume the winning code
    always_comb begin
        cnt_left  = cnt_reg - CNT_W'(best_len_reg);
        left_mask = ~({BUF_W{1'b1}} << cnt_left);
        term      = (nres_reg + 1'b1 == NRES_W'(hufd_pkg::RESULT_LIMIT))
                    || (emitted_reg + 32'd1 == total_reg);
        new_res.symbol   = best_sym_reg;
        new_res.last     = term;
        new_res.done_res = (emitted_reg + 32'd1 == total_reg);
        new_res.error    = 1'b0;
    end

    // sequencer
    always_comb begin
        state_next    = state_reg;
        total_next    = total_reg;
        entries_next  = entries_reg;
        buf_next      = buf_reg;
        cnt_next      = cnt_reg;
        emitted_next  = emitted_reg;
        err_next      = err_reg;
        nres_next     = nres_reg;
        issue_next    = issue_reg;
        cmp_v_next    = 1'b0;
        found_next    = found_reg;
        best_len_next = best_len_reg;
        best_sym_next = best_sym_reg;
        pend_v_next   = pend_v_reg;
        pend_next     = pend_reg;
        m_valid_next  = m_valid_reg && !m_tready;
        m_res_next    = m_res_reg;

        // configuration writes
        if (cfg_valid) begin
            case (cfg_index)
                hufd_pkg::REG_SYMBOL_TOTAL:  total_next   = cfg_data;
                hufd_pkg::REG_TABLE_ENTRIES: entries_next = cfg_data[8:0];
                default: ;
            endcase
        end

        unique case (state_reg)
            ST_IDLE: begin
                if (pop_valid && !pop_item.is_load && stream_live) begin
                    buf_next   = {buf_reg[BUF_W-9:0], pop_item.data_byte};
                    cnt_next   = cnt_reg + CNT_W'(8);
                    nres_next  = '0;
                    issue_next = '0;
                    found_next = 1'b0;
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN: begin
                if (ram_rd_en) begin
                    issue_next = issue_reg + 1'b1;
                    cmp_v_next = 1'b1;
                end
                if (cmp_v_reg && better) begin
                    found_next    = 1'b1;
                    best_len_next = rd_entry.length;
                    best_sym_next = rd_entry.symbol;
                end
                if (!ram_rd_en && !cmp_v_reg) begin
                    state_next = ST_DECIDE;
                end
            end
            ST_DECIDE: begin
                if (out_free) begin
                    if (pend_v_reg && (found_reg || cnt_reg >= CNT_W'(MAX_CODE_LEN))) begin
                        m_valid_next = 1'b1;
                        m_res_next   = pend_reg;
                    end
                    if (found_reg) begin
                        cnt_next     = cnt_left;
                        buf_next     = buf_reg & left_mask;
                        emitted_next = emitted_reg + 32'd1;
                        nres_next    = nres_reg + 1'b1;
                        pend_v_next  = 1'b1;
                        pend_next    = new_res;
                        issue_next   = '0;
                        found_next   = 1'b0;
                        state_next   = term ? ST_FLUSH : ST_SCAN;
                    end else if (cnt_reg >= CNT_W'(MAX_CODE_LEN)) begin
                        err_next    = 1'b1;
                        pend_v_next = 1'b1;
                        pend_next   = '{symbol: 8'd0, last: 1'b1, done_res: 1'b0, error: 1'b1};
                        state_next  = ST_FLUSH;
                    end else if (pend_v_reg) begin
                        pend_next.last = 1'b1;
                        state_next     = ST_FLUSH;
                    end else begin
                        state_next = ST_IDLE;
                    end
                end
            end
            ST_FLUSH: begin
                if (out_free) begin
                    m_valid_next = 1'b1;
                    m_res_next   = pend_reg;
                    pend_v_next  = 1'b0;
                    state_next   = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            total_reg   <= 32'd0;
            entries_reg <= 9'd1;
            buf_reg     <= '0;
            cnt_reg     <= '0;
            emitted_reg <= 32'd0;
            err_reg     <= 1'b0;
            cmp_v_reg   <= 1'b0;
            pend_v_reg  <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            total_reg   <= total_next;
            entries_reg <= entries_next;
            buf_reg     <= buf_next;
            cnt_reg     <= cnt_next;
            emitted_reg <= emitted_next;
            err_reg     <= err_next;
            cmp_v_reg   <= cmp_v_next;
            pend_v_reg  <= pend_v_next;
            m_valid_reg <= m_valid_next;
        end
        nres_reg     <= nres_next;
        issue_reg    <= issue_next;
        found_reg    <= found_next;
        best_len_reg <= best_len_next;
        best_sym_reg <= best_sym_next;
        pend_reg     <= pend_next;
        m_res_reg    <= m_res_next;
    end
endmodule
`default_nettype wire

FILE: rtl/core/huffman_table_decoder.sv
// top level of the huffman table decoder
`default_nettype none
`include "huffman_table_decoder_assert.svh"
// Huffman decoder driven by a code table loaded over the input stream.
// tuser 0 writes one table slot, tuser 1 brings one compressed byte that
// is decoded MSB first; each byte yields up to eight symbols, tlast marks
// the final result of a byte. Transfers pass through an input register and
// a four-entry queue into the decode engine. Each table search reads the
// code ram one slot per cycle over min(table_entries, TABLE_DEPTH) slots,
// compares each slot read against the buffer front and then decides; a
// byte is taken in, searched once per symbol and once more when it stops
// on a missing match, and then hands over its final result; a table load
// is written while the engine is idle. Configuration writes are taken in
// any cycle.
module huffman_table_decoder #(
    parameter int TABLE_DEPTH  = 256,
    parameter int MAX_CODE_LEN = 32
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    // entry_index[7:0] entry_symbol[15:8] entry_length[21:16]
    // entry_code[53:22] data_byte[61:54] zero[63:62]
    input  wire logic [63:0] s_tdata,
    // mode
    input  wire logic        s_tuser,
    output logic             m_tvalid,
    input  wire logic        m_tready,
    // symbol
    output logic [7:0]       m_tdata,
    output logic             m_tlast,
    // done_res[0] error[1]
    output logic [1:0]       m_tuser,
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic        cfg_index,
    input  wire logic [31:0] cfg_data
);
    localparam int ITEM_W = $bits(hufd_pkg::item_t);

    logic              fq_valid, fq_ready, qb_valid, qb_ready;
    hufd_pkg::item_t   fq_item, qb_item;
    logic [ITEM_W-1:0] qb_bits;
    hufd_pkg::result_t res;

    assign cfg_ready = 1'b1;
    assign qb_item   = hufd_pkg::item_t'(qb_bits);
    assign m_tdata   = res.symbol;
    assign m_tlast   = res.last;
    assign m_tuser   = {res.error, res.done_res};

    hufd_front #(.TABLE_DEPTH(TABLE_DEPTH)) u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .push_valid(fq_valid),
        .push_ready(fq_ready),
        .push_item (fq_item)
    );

    hufd_queue #(.WIDTH(ITEM_W), .DEPTH(hufd_pkg::QUEUE_DEPTH)) u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push_valid(fq_valid),
        .push_ready(fq_ready),
        .push_data (fq_item),
        .pop_valid (qb_valid),
        .pop_ready (qb_ready),
        .pop_data  (qb_bits)
    );

    hufd_back #(.TABLE_DEPTH(TABLE_DEPTH), .MAX_CODE_LEN(MAX_CODE_LEN)) u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cfg_valid(cfg_valid),
        .cfg_index(cfg_index),
        .cfg_data (cfg_data),
        .pop_valid(qb_valid),
        .pop_ready(qb_ready),
        .pop_item (qb_item),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_result (res)
    );

    // an error result carries no symbol and closes its byte
    `HUFD_ASSERT_IMPLY(a_err_res, aclk, aresetn, m_tvalid && m_tuser[1], m_tlast && (m_tdata == 8'd0) && !m_tuser[0])
    // the result that completes the stream closes its byte
    `HUFD_ASSERT_IMPLY(a_done_last, aclk, aresetn, m_tvalid && m_tuser[0], m_tlast)
endmodule
`default_nettype wire
